// File: rtl/clsr_pkg.sv
package clsr_pkg;

  // value width of the generators, the table and the result
  localparam int VAL_W = 31;
  localparam int MUL_W = 16;
  localparam int PROD_W = VAL_W + MUL_W;
  localparam int FOLD_W = 32;

  localparam int TABLE_DEPTH_DEF = 32;

  // input operation codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  // generator one: multiplier 40014, modulus 2^31 - 85
  localparam logic [31:0] MOD_ONE = 32'd2147483563;
  localparam logic [MUL_W-1:0] MUL_ONE = 16'd40014;
  localparam logic [7:0] FOLD_ONE = 8'd85;

  // generator two: multiplier 40692, modulus 2^31 - 249
  localparam logic [31:0] MOD_TWO = 32'd2147483399;
  localparam logic [MUL_W-1:0] MUL_TWO = 16'd40692;
  localparam logic [7:0] FOLD_TWO = 8'd249;

  localparam logic [31:0] WRAP_ADD = 32'd2147483562;
  localparam logic [VAL_W-1:0] DEF_TWO = 31'd123456789;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [FOLD_W-1:0] fold_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_seed;  // set both generators to the seed
    logic seed_in;    // seed comes from the input item (else one)
    logic mul;        // register both products
    logic fold;       // fold high product bits into low part
    logic red_one;    // load reduced generator one
    logic red_two;    // load reduced generator two
    logic fill_we;    // write reduced generator one into the table
    logic set_prev;   // previous output takes reduced generator one
    logic slot_load;  // latch slot index from previous output
    logic rd;         // read the table slot
    logic finish;     // combine, refill slot, load result
  } cmd_t;

  // p = hi*2^31 + lo, and 2^31 = c (mod m)
  function automatic fold_t fold(input prod_t p, input logic [7:0] c);
    logic [23:0] t;
    t = 24'(p[PROD_W-1:VAL_W]) * 24'(c);
    return {1'b0, p[VAL_W-1:0]} + {8'b0, t};
  endfunction

  // folded value is below twice the modulus
  function automatic val_t reduce(input fold_t f, input logic [31:0] m);
    fold_t d;
    d = f - m;
    return (f >= m) ? d[VAL_W-1:0] : f[VAL_W-1:0];
  endfunction

endpackage

// File: rtl/clsr_in_if.sv
interface clsr_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [clsr_pkg::VAL_W-1:0] seed;

  modport source (output valid, output op, output seed, input ready);
  modport sink (input valid, input op, input seed, output ready);
endinterface

// File: rtl/clsr_out_if.sv
interface clsr_out_if;
  logic valid;
  logic ready;
  logic [clsr_pkg::VAL_W-1:0] rand_value;

  modport source (output valid, output rand_value, input ready);
  modport sink (input valid, input rand_value, output ready);
endinterface

// File: rtl/combined_lcg_shuffle_rng_core.sv
// Channel   Dir  Payload                 Transfer
// rng_in    in   op (1), seed (31)       valid & ready
// rng_out   out  rand_value (31)         valid & ready
//
// A draw registers the products at the transfer, then folds them, reduces them
// and combines generator two with the table slot, which loads the result register.
// A reseed (or a draw while unseeded) first runs the warm-up steps; each warm-up
// step runs the same multiply unit.
// Reset is synchronous; after it the generators are unseeded and the first
// draw seeds with one. The result waits in an output register; while it is
// full the next draw holds in its last step.
module combined_lcg_shuffle_rng_core #(
  parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  clsr_in_if.sink     rng_in,
  clsr_out_if.source  rng_out
);
  import clsr_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  cmd_t cmd;
  logic [IDX_W-1:0] fill_idx;
  logic g1_zero;

  clsr_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rng_in.valid),
    .in_op     (rng_in.op),
    .in_ready  (rng_in.ready),
    .g1_zero   (g1_zero),
    .out_ready (rng_out.ready),
    .out_valid (rng_out.valid),
    .cmd       (cmd),
    .fill_idx  (fill_idx)
  );

  clsr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .fill_idx   (fill_idx),
    .seed       (rng_in.seed),
    .g1_zero    (g1_zero),
    .rand_value (rng_out.rand_value)
  );

endmodule

// File: rtl/clsr_table.sv
module clsr_table #(
  parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic                    clk,
  input  clsr_pkg::val_t          prev,
  input  logic                    slot_load,
  input  logic                    rd_en,
  input  logic                    wr_en,
  input  logic                    wr_fill,
  input  logic [IDX_W-1:0]        fill_idx,
  input  clsr_pkg::val_t          wr_data,
  output clsr_pkg::val_t          rd_data
);
  import clsr_pkg::*;

  localparam logic [31:0] NDIV = 32'(1 + (MOD_ONE - 1) / TABLE_DEPTH);

  val_t mem [TABLE_DEPTH];
  logic [IDX_W-1:0] slot_q;
  logic [IDX_W-1:0] slot_c;
  logic [TABLE_DEPTH:0] ge;
  logic [IDX_W-1:0] waddr;

  // slot = prev / NDIV: thermometer of constant thresholds, then encode
  always_comb begin
    ge = '0;
    ge[0] = 1'b1;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      ge[k] = ({1'b0, prev} >= 32'(k) * NDIV);
    end
    slot_c = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (ge[k] && !ge[k+1]) slot_c = slot_c | IDX_W'(k);
    end
  end

  assign waddr = wr_fill ? fill_idx : slot_q;

  // shuffle table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (slot_load) slot_q <= slot_c;
    if (wr_en) mem[waddr] <= wr_data;
    if (rd_en) rd_data <= mem[slot_q];
  end

endmodule

// File: rtl/clsr_dp.sv
module clsr_dp #(
  parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  clsr_pkg::cmd_t     cmd,
  input  logic [IDX_W-1:0]   fill_idx,
  input  clsr_pkg::val_t     seed,
  output logic               g1_zero,
  output clsr_pkg::val_t     rand_value
);
  import clsr_pkg::*;

  val_t  g1, g2, prev;
  prod_t p1, p2;
  fold_t f1, f2;
  val_t  red1, red2, seed_val, rd_data, res, wr_data;
  logic [31:0] diff, sum;

  assign red1 = reduce(f1, MOD_ONE);
  assign red2 = reduce(f2, MOD_TWO);
  assign g1_zero = (g1 == '0);
  assign seed_val = (cmd.seed_in && seed != '0) ? seed : val_t'(1);

  // slot minus generator two, wrapped into 1..MOD_ONE-1
  assign diff = {1'b0, rd_data} - {1'b0, g2};
  assign sum = (rd_data <= g2) ? diff + WRAP_ADD : diff;
  assign res = sum[VAL_W-1:0];

  // generator and previous-output state
  always_ff @(posedge clk) begin
    if (rst) begin
      g1 <= '0;
      g2 <= DEF_TWO;
      prev <= '0;
    end else begin
      if (cmd.load_seed) begin
        g1 <= seed_val;
        g2 <= seed_val;
      end
      if (cmd.red_one) g1 <= red1;
      if (cmd.red_two) g2 <= red2;
      if (cmd.set_prev) prev <= red1;
      if (cmd.finish) prev <= res;
    end
  end

  // modular multiply pipeline and result register
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p1 <= PROD_W'(g1) * PROD_W'(MUL_ONE);
      p2 <= PROD_W'(g2) * PROD_W'(MUL_TWO);
    end
    if (cmd.fold) begin
      f1 <= fold(p1, FOLD_ONE);
      f2 <= fold(p2, FOLD_TWO);
    end
    if (cmd.finish) rand_value <= res;
  end

  assign wr_data = cmd.fill_we ? red1 : g1;

  clsr_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk       (clk),
    .prev      (prev),
    .slot_load (cmd.slot_load),
    .rd_en     (cmd.rd),
    .wr_en     (cmd.fill_we | cmd.finish),
    .wr_fill   (cmd.fill_we),
    .fill_idx  (fill_idx),
    .wr_data   (wr_data),
    .rd_data   (rd_data)
  );

endmodule

// File: rtl/clsr_ctrl.sv
module clsr_ctrl #(
  parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  input  logic               g1_zero,
  input  logic               out_ready,
  output logic               out_valid,
  output clsr_pkg::cmd_t     cmd,
  output logic [IDX_W-1:0]   fill_idx
);
  import clsr_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 8);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(TABLE_DEPTH + 7);
  localparam logic [CNT_W-1:0] CNT_FILL = CNT_W'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SMUL  = 4'd1;
  localparam logic [3:0] S_SFOLD = 4'd2;
  localparam logic [3:0] S_SRED  = 4'd3;
  localparam logic [3:0] S_DMUL  = 4'd4;
  localparam logic [3:0] S_DFOLD = 4'd5;
  localparam logic [3:0] S_DRED  = 4'd6;
  localparam logic [3:0] S_DOUT  = 4'd7;

  logic [3:0] state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic out_valid_next;
  logic accept, do_seed;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign do_seed = (in_op == OP_RESEED) || g1_zero;
  assign fill_idx = cnt[IDX_W-1:0];

  // sequencer: seeding warm-up steps, then the four-step draw
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (do_seed) begin
            cmd.load_seed = 1'b1;
            cmd.seed_in = (in_op == OP_RESEED);
            cnt_next = CNT_START;
            state_next = S_SMUL;
          end else begin
            cmd.mul = 1'b1;
            cmd.slot_load = 1'b1;
            state_next = S_DFOLD;
          end
        end
      end
      S_SMUL: begin
        cmd.mul = 1'b1;
        state_next = S_SFOLD;
      end
      S_SFOLD: begin
        cmd.fold = 1'b1;
        state_next = S_SRED;
      end
      S_SRED: begin
        cmd.red_one = 1'b1;
        cmd.fill_we = (cnt < CNT_FILL);
        if (cnt == '0) begin
          cmd.set_prev = 1'b1;
          state_next = S_DMUL;
        end else begin
          cnt_next = cnt - 1'b1;
          state_next = S_SMUL;
        end
      end
      S_DMUL: begin
        cmd.mul = 1'b1;
        cmd.slot_load = 1'b1;
        state_next = S_DFOLD;
      end
      S_DFOLD: begin
        cmd.fold = 1'b1;
        cmd.rd = 1'b1;
        state_next = S_DRED;
      end
      S_DRED: begin
        cmd.red_one = 1'b1;
        cmd.red_two = 1'b1;
        state_next = S_DOUT;
      end
      S_DOUT: begin
        // wait here while the result register still holds a value
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: bench/clsr_draw_checker.sv
// Watches both channels, predicts every draw and compares each returned value.
module clsr_draw_checker #(
  parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  clsr_in_if          rng_in,
  clsr_out_if         rng_out,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned checked
);
  import clsr_pkg::*;

  // divisor that maps the previous value onto a table slot
  localparam logic [31:0] SLOT_DIV = 32'd1 + WRAP_ADD / 32'(TABLE_DEPTH);

  // predictor state
  val_t gen_one;
  val_t gen_two;
  val_t last_value;
  val_t slots [TABLE_DEPTH];
  val_t predicted_draws [$];

  function automatic val_t lcg_one(input val_t z);
    logic [63:0] p;
    p = (64'(z) * 64'(MUL_ONE)) % 64'(MOD_ONE);
    return p[VAL_W-1:0];
  endfunction

  function automatic val_t lcg_two(input val_t z);
    logic [63:0] p;
    p = (64'(z) * 64'(MUL_TWO)) % 64'(MOD_TWO);
    return p[VAL_W-1:0];
  endfunction

  // warm-up: the last TABLE_DEPTH steps of generator one fill the table top-down
  function automatic void seed_generators(input val_t s);
    val_t g;
    g = (s == '0) ? val_t'(1) : s;
    gen_one = g;
    gen_two = g;
    for (int n = TABLE_DEPTH + 7; n >= 0; n--) begin
      gen_one = lcg_one(gen_one);
      if (n < TABLE_DEPTH) slots[n] = gen_one;
    end
    last_value = slots[0];
  endfunction

  function automatic val_t draw_value(input logic op, input val_t seed);
    logic [31:0] idx;
    longint diff;
    // an unseeded (or collapsed) generator one forces a seed of one
    if (op == OP_RESEED) seed_generators(seed);
    else if (gen_one == '0) seed_generators('0);
    gen_one = lcg_one(gen_one);
    gen_two = lcg_two(gen_two);
    idx = {1'b0, last_value} / SLOT_DIV;
    if (idx >= 32'(TABLE_DEPTH)) idx = 32'(TABLE_DEPTH - 1);
    diff = longint'(slots[idx]) - longint'(gen_two);
    slots[idx] = gen_one;
    if (diff < 1) diff += longint'(WRAP_ADD);
    last_value = diff[VAL_W-1:0];
    return last_value;
  endfunction

  // results are checked before the same-edge input transfer is predicted
  always @(posedge clk) begin
    val_t want;
    if (rst) begin
      gen_one = '0;
      gen_two = DEF_TWO;
      last_value = '0;
      foreach (slots[k]) slots[k] = '0;
      predicted_draws.delete();
    end else begin
      if (rng_out.valid && rng_out.ready) begin
        checked++;
        if (predicted_draws.size() == 0) begin
          fail_count++;
          $display("%0t: rand_value expected none, got %0d", $time, rng_out.rand_value);
        end else begin
          want = predicted_draws.pop_front();
          if (rng_out.rand_value !== want) begin
            fail_count++;
            $display("%0t: rand_value expected %0d, got %0d", $time, want,
                     rng_out.rand_value);
          end
        end
      end
      if (rng_in.valid && rng_in.ready)
        predicted_draws.push_back(draw_value(rng_in.op, rng_in.seed));
    end
    pending = predicted_draws.size();
  end

endmodule

// File: bench/combined_lcg_shuffle_rng_core_test.sv
module combined_lcg_shuffle_rng_core_test;
  import clsr_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  clsr_in_if rng_in ();
  clsr_out_if rng_out ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned draws;
  int unsigned reseeds;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  int unsigned sink_cycles;
  logic src_calm;
  logic sink_calm;

  combined_lcg_shuffle_rng_core dut (
    .clk     (clk),
    .rst     (rst),
    .rng_in  (rng_in),
    .rng_out (rng_out)
  );

  clsr_draw_checker draw_check (
    .clk        (clk),
    .rst        (rst),
    .rng_in     (rng_in),
    .rng_out    (rng_out),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input transfer, then an optional idle gap
  task automatic push_item(input logic op, input val_t seed);
    int unsigned gap;
    rng_in.valid <= 1'b1;
    rng_in.op <= op;
    rng_in.seed <= seed;
    do @(posedge clk); while (!rng_in.ready);
    @(negedge clk);
    if (op == OP_RESEED) reseeds++;
    else draws++;
    gap = src_calm ? 0 : pick_gap();
    if (gap != 0) begin
      rng_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // result side back-pressure, with calm stretches
  always @(negedge clk) begin
    sink_cycles <= sink_cycles + 1;
    if (sink_cycles % 256 == 255) sink_calm <= ($urandom_range(0, 2) == 0);
    if (stall_left != 0) begin
      rng_out.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rng_out.ready <= 1'b1;
      if (!sink_calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // end the run if no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (rng_in.valid && rng_in.ready) || (rng_out.valid && rng_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: %0d results still expected", pending);
        $display("combined_lcg_shuffle_rng_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    val_t s;
    rng_in.valid = 1'b0;
    rng_in.op = OP_DRAW;
    rng_in.seed = '0;
    rng_out.ready = 1'b0;
    src_calm = 1'b0;
    sink_calm = 1'b0;
    stall_left = 0;
    sink_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: draw before any seed, extreme seeds, generator one collapsing
    push_item(OP_DRAW, 31'h1234_5678);
    push_item(OP_DRAW, '0);
    push_item(OP_RESEED, '0);
    push_item(OP_DRAW, '1);
    push_item(OP_RESEED, 31'd1);
    push_item(OP_RESEED, '1);
    push_item(OP_DRAW, '0);
    push_item(OP_RESEED, WRAP_ADD[VAL_W-1:0]);
    push_item(OP_DRAW, '0);
    // seed equal to modulus one: generator one goes to zero, next draw reseeds
    push_item(OP_RESEED, MOD_ONE[VAL_W-1:0]);
    push_item(OP_DRAW, '0);
    push_item(OP_DRAW, '1);
    // seed equal to modulus two: generator two stays zero
    push_item(OP_RESEED, MOD_TWO[VAL_W-1:0]);
    push_item(OP_DRAW, '0);
    push_item(OP_DRAW, '0);
    push_item(OP_DRAW, '0);
    push_item(OP_RESEED, 31'h5555_5555);
    push_item(OP_DRAW, 31'h2AAA_AAAA);
    push_item(OP_RESEED, 31'h2AAA_AAAA);
    push_item(OP_DRAW, 31'h5555_5555);

    // random: long draw runs with occasional reseeds
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 149) == 0) src_calm = !src_calm;
      if ($urandom_range(0, 24) == 0) begin
        case ($urandom_range(0, 9))
          0: s = '0;
          1: s = MOD_ONE[VAL_W-1:0];
          2: s = MOD_TWO[VAL_W-1:0];
          3: s = '1;
          default: s = 31'($urandom());
        endcase
        push_item(OP_RESEED, s);
      end else begin
        push_item(OP_DRAW, 31'($urandom()));
      end
    end
    rng_in.valid <= 1'b0;

    wait (pending == 0);
    repeat (12) @(posedge clk);
    $display("Stimulus: %0d draws and %0d reseeds, including unseeded and collapsed cases.",
             draws, reseeds);
    $display("Compared %0d returned values with %0d failures.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("combined_lcg_shuffle_rng_core: match");
    end else begin
      $display("combined_lcg_shuffle_rng_core: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/clsr_pkg.sv
rtl/clsr_in_if.sv
rtl/clsr_out_if.sv
rtl/clsr_table.sv
rtl/clsr_dp.sv
rtl/clsr_ctrl.sv
rtl/combined_lcg_shuffle_rng_core.sv
bench/clsr_draw_checker.sv
bench/combined_lcg_shuffle_rng_core_test.sv
